// File: src/iws_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// IMU window stillness detector package
// Shared sizes, types and sequencer states of the stillness detector.
// ============================================================================
package iws_pkg;

    localparam int WINDOW         = 16;
    localparam int SAMPLE_BITS    = 16;
    localparam int IN_W           = 16;
    localparam int CHANNELS       = 7;
    localparam int ACCEL_CHANNELS = 4;
    localparam int PERCENT_SCALE  = 100;
    localparam int TOL_W          = 7;
    localparam logic [TOL_W-1:0] TOL_RESET = 7'd5;

    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;
    localparam logic REG_TOLERANCE = 1'b0;

    localparam int SLOT_W  = $clog2(WINDOW);
    localparam int FILL_W  = $clog2(WINDOW + 1);
    localparam int CH_W    = $clog2(CHANNELS);
    localparam int ROW_W   = CHANNELS * SAMPLE_BITS;
    localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW);
    localparam int LHS_K   = PERCENT_SCALE * WINDOW;
    localparam int LHS_KW  = $clog2(LHS_K + 1);
    localparam int LHS_W   = SAMPLE_BITS + LHS_KW;
    localparam int RHS_W   = SUM_W + TOL_W;
    localparam int CMP_W   = (LHS_W > RHS_W) ? LHS_W : RHS_W;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [SUM_W-1:0]       t_sum;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_CHECK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic live;
        logic first;
        logic keep;
    } t_acc_ctrl;

    typedef struct packed {
        logic            live;
        logic            first;
        logic [CH_W-1:0] ch;
    } t_chk_ctrl;

endpackage

// File: src/iws_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// Generic RAM
// One write port and one read port, read data registered.
// ============================================================================
module iws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/iws_acc.sv
`timescale 1ns / 1ps
// ============================================================================
// Window accumulator
// Folds one window row per cycle into per-channel minimum, maximum and sum.
// ============================================================================
module iws_acc (
    input  logic                    i_clk,
    input  iws_pkg::t_acc_ctrl      i_ctrl,
    input  logic [iws_pkg::ROW_W-1:0] i_row,
    output iws_pkg::t_sample        o_min [iws_pkg::CHANNELS],
    output iws_pkg::t_sample        o_max [iws_pkg::CHANNELS],
    output iws_pkg::t_sum           o_sum [iws_pkg::CHANNELS]
);

    iws_pkg::t_sample r_min [iws_pkg::CHANNELS];
    iws_pkg::t_sample r_max [iws_pkg::CHANNELS];
    iws_pkg::t_sum    r_sum [iws_pkg::CHANNELS];
    iws_pkg::t_sample s     [iws_pkg::CHANNELS];

    always_comb begin
        for (int c = 0; c < iws_pkg::CHANNELS; c++) begin
            s[c] = i_ctrl.keep ? iws_pkg::t_sample'(i_row[c*iws_pkg::SAMPLE_BITS +:
                                                     iws_pkg::SAMPLE_BITS])
                               : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.live) begin
            for (int c = 0; c < iws_pkg::CHANNELS; c++) begin
                if (i_ctrl.first) begin
                    r_min[c] <= s[c];
                    r_max[c] <= s[c];
                    r_sum[c] <= iws_pkg::SUM_W'(s[c]);
                end else begin
                    if (s[c] < r_min[c]) begin
                        r_min[c] <= s[c];
                    end
                    if (s[c] > r_max[c]) begin
                        r_max[c] <= s[c];
                    end
                    r_sum[c] <= r_sum[c] + iws_pkg::SUM_W'(s[c]);
                end
            end
        end
    end

    assign o_min = r_min;
    assign o_max = r_max;
    assign o_sum = r_sum;

endmodule

// File: src/iws_chk.sv
`timescale 1ns / 1ps
// ============================================================================
// Spread check
// Tests one channel per cycle against the tolerance and gathers the flags.
// ============================================================================
module iws_chk (
    input  logic                      i_clk,
    input  iws_pkg::t_chk_ctrl        i_ctrl,
    input  logic [iws_pkg::TOL_W-1:0] i_tol,
    input  iws_pkg::t_sample          i_min [iws_pkg::CHANNELS],
    input  iws_pkg::t_sample          i_max [iws_pkg::CHANNELS],
    input  iws_pkg::t_sum             i_sum [iws_pkg::CHANNELS],
    output logic                      o_accel_ok,
    output logic                      o_gyro_ok
);

    logic signed [iws_pkg::SAMPLE_BITS:0] diff;
    logic [iws_pkg::SAMPLE_BITS-1:0]      range_v;
    iws_pkg::t_sum                        sum_v;
    logic [iws_pkg::SUM_W-1:0]            mag;
    logic [iws_pkg::CMP_W-1:0]            lhs;
    logic [iws_pkg::CMP_W-1:0]            rhs;
    logic                                 ok;
    logic                                 is_accel;
    logic                                 r_accel_ok;
    logic                                 r_gyro_ok;

    always_comb begin
        diff     = (iws_pkg::SAMPLE_BITS + 1)'(i_max[i_ctrl.ch])
                 - (iws_pkg::SAMPLE_BITS + 1)'(i_min[i_ctrl.ch]);
        range_v  = diff[iws_pkg::SAMPLE_BITS-1:0];
        sum_v    = i_sum[i_ctrl.ch];
        mag      = sum_v[iws_pkg::SUM_W-1] ? iws_pkg::SUM_W'(-sum_v) : sum_v;
        lhs      = iws_pkg::CMP_W'(range_v) * iws_pkg::CMP_W'(iws_pkg::LHS_K);
        rhs      = iws_pkg::CMP_W'(i_tol) * iws_pkg::CMP_W'(mag);
        ok       = (lhs <= rhs);
        is_accel = (i_ctrl.ch < iws_pkg::CH_W'(iws_pkg::ACCEL_CHANNELS));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.live) begin
            if (i_ctrl.first) begin
                r_accel_ok <= is_accel ? ok : 1'b1;
                r_gyro_ok  <= is_accel ? 1'b1 : ok;
            end else if (is_accel) begin
                r_accel_ok <= r_accel_ok & ok;
            end else begin
                r_gyro_ok  <= r_gyro_ok & ok;
            end
        end
    end

    assign o_accel_ok = r_accel_ok;
    assign o_gyro_ok  = r_gyro_ok;

endmodule

// File: src/imu_window_stillness_detector.sv
`timescale 1ns / 1ps
// ============================================================================
// IMU window stillness detector
// Keeps the last samples of seven IMU channels and flags a still sensor.
// ============================================================================
// Usage:
// The input channel takes one word of seven signed samples when i_valid is
// high and o_stall is low. The sample replaces the oldest entry of the window.
// The block then reads the window RAM one row a cycle through its registered
// read port, and checks the seven channels one a cycle through a single
// multiply and compare unit. The result word appears on o_valid; o_stall is
// high from acceptance until the result is loaded, so no new word is taken
// before that. A result waits in the output register while i_stall is high;
// a new word is still accepted meanwhile, and its result is held back until
// the register is free. Reset empties the window (rows never written read as
// zero by a fill count), clears o_valid and sets the tolerance register to 5.
// The tolerance is written through the APB port at any address with paddr[2]
// low, such as address 0.
// ============================================================================
module imu_window_stillness_detector (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [iws_pkg::IN_W-1:0] i_accel_x,
    input  logic signed [iws_pkg::IN_W-1:0] i_accel_y,
    input  logic signed [iws_pkg::IN_W-1:0] i_accel_z,
    input  logic signed [iws_pkg::IN_W-1:0] i_high_g_z,
    input  logic signed [iws_pkg::IN_W-1:0] i_gyro_x,
    input  logic signed [iws_pkg::IN_W-1:0] i_gyro_y,
    input  logic signed [iws_pkg::IN_W-1:0] i_gyro_z,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_accel_steady,
    output logic                        o_gyro_steady,
    output logic                        o_still,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [iws_pkg::ADDR_W-1:0]  paddr,
    input  logic [iws_pkg::DATA_W-1:0]  pwdata,
    output logic [iws_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    iws_pkg::t_state                 r_state, n_state;
    logic [iws_pkg::SLOT_W-1:0]      r_slot;
    logic [iws_pkg::FILL_W-1:0]      r_filled;
    logic [iws_pkg::SLOT_W-1:0]      r_addr, n_addr;
    logic                            r_rd_v;
    logic [iws_pkg::SLOT_W-1:0]      r_rd_idx;
    logic [iws_pkg::CH_W-1:0]        r_ch, n_ch;
    logic [iws_pkg::TOL_W-1:0]       r_tol;
    logic                            r_out_valid;
    logic                            r_out_acc;
    logic                            r_out_gyr;

    logic                            accept;
    logic                            out_free;
    logic                            load_out;
    logic                            scan_rd;
    logic [iws_pkg::ROW_W-1:0]       wr_row;
    logic [iws_pkg::ROW_W-1:0]       rd_row;
    logic                            accel_ok;
    logic                            gyro_ok;
    iws_pkg::t_acc_ctrl              acc_ctrl;
    iws_pkg::t_chk_ctrl              chk_ctrl;
    iws_pkg::t_sample                acc_min [iws_pkg::CHANNELS];
    iws_pkg::t_sample                acc_max [iws_pkg::CHANNELS];
    iws_pkg::t_sum                   acc_sum [iws_pkg::CHANNELS];
    logic [iws_pkg::IN_W-1:0]        in_raw  [iws_pkg::CHANNELS];
    logic [iws_pkg::IN_W+iws_pkg::SAMPLE_BITS-1:0] in_ext [iws_pkg::CHANNELS];

    localparam logic [iws_pkg::SLOT_W-1:0] LAST_SLOT = iws_pkg::SLOT_W'(iws_pkg::WINDOW - 1);
    localparam logic [iws_pkg::CH_W-1:0]   LAST_CH   = iws_pkg::CH_W'(iws_pkg::CHANNELS - 1);

    assign in_raw[0] = i_accel_x;
    assign in_raw[1] = i_accel_y;
    assign in_raw[2] = i_accel_z;
    assign in_raw[3] = i_high_g_z;
    assign in_raw[4] = i_gyro_x;
    assign in_raw[5] = i_gyro_y;
    assign in_raw[6] = i_gyro_z;

    always_comb begin
        for (int c = 0; c < iws_pkg::CHANNELS; c++) begin
            in_ext[c] = {{iws_pkg::SAMPLE_BITS{1'b0}}, in_raw[c]};
            wr_row[c*iws_pkg::SAMPLE_BITS +: iws_pkg::SAMPLE_BITS] =
                in_ext[c][iws_pkg::SAMPLE_BITS-1:0];
        end
    end

    assign accept   = i_valid & ~o_stall;
    assign out_free = ~r_out_valid | ~i_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            iws_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = iws_pkg::ST_SCAN;
                end
            end
            iws_pkg::ST_SCAN: begin
                if (r_addr == LAST_SLOT) begin
                    n_state = iws_pkg::ST_DRAIN;
                end
            end
            iws_pkg::ST_DRAIN: begin
                n_state = iws_pkg::ST_CHECK;
            end
            iws_pkg::ST_CHECK: begin
                if (r_ch == LAST_CH) begin
                    n_state = iws_pkg::ST_DONE;
                end
            end
            iws_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = iws_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = iws_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_stall        = 1'b1;
        scan_rd        = 1'b0;
        load_out       = 1'b0;
        chk_ctrl.live  = 1'b0;
        chk_ctrl.first = (r_ch == '0);
        chk_ctrl.ch    = r_ch;
        n_addr         = r_addr;
        n_ch           = r_ch;
        case (r_state)
            iws_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                n_addr  = '0;
                n_ch    = '0;
            end
            iws_pkg::ST_SCAN: begin
                scan_rd = 1'b1;
                n_addr  = (r_addr == LAST_SLOT) ? '0 : r_addr + 1'b1;
            end
            iws_pkg::ST_CHECK: begin
                chk_ctrl.live = 1'b1;
                n_ch          = r_ch + 1'b1;
            end
            iws_pkg::ST_DONE: begin
                load_out = out_free;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    assign acc_ctrl.live  = r_rd_v;
    assign acc_ctrl.first = (r_rd_idx == '0);
    assign acc_ctrl.keep  = (iws_pkg::FILL_W'(r_rd_idx) < r_filled);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= iws_pkg::ST_IDLE;
            r_slot      <= '0;
            r_filled    <= '0;
            r_addr      <= '0;
            r_ch        <= '0;
            r_rd_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_ch    <= n_ch;
            r_rd_v  <= scan_rd;
            if (accept) begin
                r_slot <= (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
                if (r_filled != iws_pkg::FILL_W'(iws_pkg::WINDOW)) begin
                    r_filled <= r_filled + 1'b1;
                end
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr;
        if (load_out) begin
            r_out_acc <= accel_ok;
            r_out_gyr <= gyro_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= iws_pkg::TOL_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == iws_pkg::REG_TOLERANCE) begin
            r_tol <= pwdata[iws_pkg::TOL_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == iws_pkg::REG_TOLERANCE)
                  ? iws_pkg::DATA_W'(r_tol) : '0;

    iws_ram #(
        .WIDTH(iws_pkg::ROW_W),
        .DEPTH(iws_pkg::WINDOW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (accept),
        .i_waddr(r_slot),
        .i_wdata(wr_row),
        .i_raddr(r_addr),
        .o_rdata(rd_row)
    );

    iws_acc u_acc (
        .i_clk (i_clk),
        .i_ctrl(acc_ctrl),
        .i_row (rd_row),
        .o_min (acc_min),
        .o_max (acc_max),
        .o_sum (acc_sum)
    );

    iws_chk u_chk (
        .i_clk     (i_clk),
        .i_ctrl    (chk_ctrl),
        .i_tol     (r_tol),
        .i_min     (acc_min),
        .i_max     (acc_max),
        .i_sum     (acc_sum),
        .o_accel_ok(accel_ok),
        .o_gyro_ok (gyro_ok)
    );

    assign o_valid        = r_out_valid;
    assign o_accel_steady = r_out_acc;
    assign o_gyro_steady  = r_out_gyr;
    assign o_still        = r_out_acc & r_out_gyr;

endmodule
